// ===== src/rpwu_pkg.sv =====
// rpwu_pkg: shared types and constants of the rprop weight update engine
package rpwu_pkg;

    localparam int IDX_W      = 10;   // weight index width
    localparam int VAL_W      = 32;   // signed q16.16 values
    localparam int STEP_W     = 22;   // unsigned q6.16 step sizes
    localparam int FAC_W      = 16;   // unsigned q4.12 factors
    localparam int ALG_W      = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 22;
    localparam int FRAC_SHIFT = 12;   // q4.12 factor fraction bits

    // step limits, 0.0001 and 50.0 in q6.16
    localparam logic [STEP_W-1:0] STEP_MIN = STEP_W'(7);
    localparam logic [STEP_W-1:0] STEP_MAX = STEP_W'(3276800);

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_UPDATE = 1'b1;

    typedef enum logic [ALG_W-1:0] {
        ALG_MOMENTUM     = 3'd0,
        ALG_RPROP        = 3'd1,
        ALG_RPROP_PLUS   = 3'd2,
        ALG_RPROP_MINUS  = 3'd3,
        ALG_IRPROP_PLUS  = 3'd4,
        ALG_IRPROP_MINUS = 3'd5
    } t_algo;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALGORITHM       = 3'd0,
        CFG_GAIN            = 3'd1,
        CFG_MOMENTUM_FACTOR = 3'd2,
        CFG_GROW_FACTOR     = 3'd3,
        CFG_SHRINK_FACTOR   = 3'd4,
        CFG_INITIAL_STEP    = 3'd5
    } t_cfg_reg;

    // one entry of the weight table
    typedef struct packed {
        logic signed [VAL_W-1:0] weight;
        logic [STEP_W-1:0]       step;
        logic signed [VAL_W-1:0] prev_grad;
        logic signed [VAL_W-1:0] last_change;
    } t_entry;

endpackage

// ===== src/rpwu_if.sv =====
// rpwu_if: request and response channel interfaces
interface rpwu_req_if import rpwu_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    req_type;
    logic [IDX_W-1:0]        weight_index;
    logic signed [VAL_W-1:0] load_value;
    logic signed [VAL_W-1:0] gradient;
    logic                    error_increased;

    modport source (
        output valid, req_type, weight_index, load_value, gradient, error_increased,
        input  ready
    );
    modport sink (
        input  valid, req_type, weight_index, load_value, gradient, error_increased,
        output ready
    );
endinterface

interface rpwu_rsp_if import rpwu_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [IDX_W-1:0]        out_index;
    logic signed [VAL_W-1:0] new_weight;
    logic [STEP_W-1:0]       new_step;

    modport source (
        output valid, out_index, new_weight, new_step,
        input  ready
    );
    modport sink (
        input  valid, out_index, new_weight, new_step,
        output ready
    );
endinterface

// ===== src/rpwu_ram.sv =====
// rpwu_ram: generic simple dual port ram with registered read
module rpwu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/rpwu_idx_mod.sv =====
// rpwu_idx_mod: reduces a weight index modulo the table depth
module rpwu_idx_mod import rpwu_pkg::*; #(
    parameter int NUM_WEIGHTS = 1024
) (
    input  logic [IDX_W-1:0] i_idx,
    output logic [IDX_W-1:0] o_idx
);
    localparam int  IDX_RANGE = 2 ** IDX_W;
    localparam bit  FITS      = NUM_WEIGHTS >= IDX_RANGE;
    localparam bit  POW2      = (NUM_WEIGHTS & (NUM_WEIGHTS - 1)) == 0;
    localparam int  RSH       = 2 * IDX_W;
    localparam int  RCP_W     = RSH + 1;
    localparam int  PROD_W    = IDX_W + RCP_W;

    generate
        if (FITS) begin : g_fits
            // every index already lies inside the table
            assign o_idx = i_idx;
        end else if (POW2) begin : g_mask
            localparam logic [IDX_W-1:0] MASK = IDX_W'(NUM_WEIGHTS - 1);
            assign o_idx = i_idx & MASK;
        end else begin : g_recip
            // quotient by reciprocal, exact for indices below 2**IDX_W
            localparam int RECIP = (2 ** RSH + NUM_WEIGHTS - 1) / NUM_WEIGHTS;
            localparam logic [IDX_W-1:0] DIVISOR = IDX_W'(NUM_WEIGHTS);
            logic [PROD_W-1:0]  w_prod;
            logic [IDX_W-1:0]   w_quot;
            logic [2*IDX_W-1:0] w_back;

            assign w_prod = PROD_W'(i_idx) * PROD_W'(RECIP);
            assign w_quot = w_prod[RSH+IDX_W-1:RSH];
            assign w_back = (2*IDX_W)'(w_quot) * (2*IDX_W)'(DIVISOR);
            assign o_idx  = i_idx - w_back[IDX_W-1:0];
        end
    endgenerate
endmodule

// ===== src/rprop_weight_update.sv =====
// rprop_weight_update: per-weight rprop / momentum training update engine
//
//   channel   dir  handshake        contents
//   i_req     in   valid / ready    req_type, weight_index, load_value, gradient,
//                                   error_increased
//   o_rsp     out  valid / ready    out_index, new_weight, new_step
//   i_cfg_*   in   write enable     register index, write data
//
// one request per cycle sustained unless an index hazard or a stalled consumer
// holds the input; stages: ram read with multiply, update, weight add, then the
// response register; the weight table is one ram with a single write port
// written in the last stage; a request to an index still in flight waits until
// its entry is written back; reset clears the pipeline valids and loads the
// register defaults; the response register decouples the pipeline from a
// stalled consumer; requests keep flowing into empty stages while a response waits
module rprop_weight_update import rpwu_pkg::*; #(
    parameter int NUM_WEIGHTS = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rpwu_req_if.sink              i_req,
    rpwu_rsp_if.source            o_rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    localparam int AW      = $clog2(NUM_WEIGHTS);
    localparam int ENT_W   = $bits(t_entry);
    localparam int SPROD_W = STEP_W + FAC_W;      // step times factor
    localparam int SQ_W    = SPROD_W - FRAC_SHIFT;
    localparam int MPROD_W = VAL_W + FAC_W + 1;   // signed value times factor
    localparam int ACC_W   = MPROD_W + 1;
    localparam int RND_W   = ACC_W - FRAC_SHIFT;
    localparam int ADD_W   = VAL_W + 1;
    localparam int SUM_W   = VAL_W + 2;
    localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(2 ** (FRAC_SHIFT - 1));
    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    // -sign(g) * step as a signed change
    function automatic logic signed [ADD_W-1:0] step_delta(
        input logic              g_pos,
        input logic              g_neg,
        input logic [STEP_W-1:0] step
    );
        logic signed [ADD_W-1:0] mag;
        mag = $signed({{(ADD_W-STEP_W){1'b0}}, step});
        if (g_pos) begin
            return -mag;
        end else if (g_neg) begin
            return mag;
        end
        return '0;
    endfunction

    function automatic logic [STEP_W-1:0] clamp_step(input logic [SQ_W-1:0] q);
        if (q > SQ_W'(STEP_MAX)) begin
            return STEP_MAX;
        end
        return q[STEP_W-1:0];
    endfunction

    // ---------------- configuration registers ----------------
    logic [ALG_W-1:0]  r_algorithm;
    logic [FAC_W-1:0]  r_gain;
    logic [FAC_W-1:0]  r_momentum_factor;
    logic [FAC_W-1:0]  r_grow_factor;
    logic [FAC_W-1:0]  r_shrink_factor;
    logic [STEP_W-1:0] r_initial_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_algorithm       <= ALG_RPROP;
            r_gain            <= FAC_W'(2867);
            r_momentum_factor <= '0;
            r_grow_factor     <= FAC_W'(4915);
            r_shrink_factor   <= FAC_W'(2048);
            r_initial_step    <= STEP_W'(6554);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ALGORITHM:       r_algorithm       <= i_cfg_data[ALG_W-1:0];
                CFG_GAIN:            r_gain            <= i_cfg_data[FAC_W-1:0];
                CFG_MOMENTUM_FACTOR: r_momentum_factor <= i_cfg_data[FAC_W-1:0];
                CFG_GROW_FACTOR:     r_grow_factor     <= i_cfg_data[FAC_W-1:0];
                CFG_SHRINK_FACTOR:   r_shrink_factor   <= i_cfg_data[FAC_W-1:0];
                CFG_INITIAL_STEP:    r_initial_step    <= i_cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic r_s1_v, r_s2_v, r_s3_v, r_out_v;
    logic w_en1, w_en2, w_en3, w_en_out;
    logic w_hazard, w_accept;
    logic [IDX_W-1:0] w_red_idx;
    logic [IDX_W-1:0] r_s1_idx, r_s2_idx, r_s3_idx, r_out_idx;

    // each stage loads when empty or when the stage after it moves
    assign w_en_out = !r_out_v || o_rsp.ready;
    assign w_en3    = !r_s3_v || w_en_out;
    assign w_en2    = !r_s2_v || w_en3;
    assign w_en1    = !r_s1_v || w_en2;

    // read-modify-write interlock: hold a request whose entry is still
    // in flight and not yet written back
    assign w_hazard = (r_s1_v && (r_s1_idx == w_red_idx))
                   || (r_s2_v && (r_s2_idx == w_red_idx))
                   || (r_s3_v && (r_s3_idx == w_red_idx));

    assign i_req.ready = w_en1 && !w_hazard;
    assign w_accept    = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (w_en1) begin
                r_s1_v <= w_accept;
            end
            if (w_en2) begin
                r_s2_v <= r_s1_v;
            end
            if (w_en3) begin
                r_s3_v <= r_s2_v;
            end
            if (w_en_out) begin
                r_out_v <= r_s3_v;
            end
        end
    end

    // ---------------- stage 0: index and table read ----------------
    rpwu_idx_mod #(
        .NUM_WEIGHTS(NUM_WEIGHTS)
    ) u_idx_mod (
        .i_idx(i_req.weight_index),
        .o_idx(w_red_idx)
    );

    logic              w_ram_we;
    logic [AW-1:0]     w_ram_waddr;
    t_entry            w_ram_wdata;
    t_entry            w_rd;

    rpwu_ram #(
        .WIDTH(ENT_W),
        .DEPTH(NUM_WEIGHTS)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (w_ram_we),
        .i_waddr(w_ram_waddr),
        .i_wdata(w_ram_wdata),
        .i_re   (w_accept),
        .i_raddr(AW'(w_red_idx)),
        .o_rdata(w_rd)
    );

    // ---------------- stage 1: entry in hand, products ----------------
    logic                    r_s1_type;
    logic signed [VAL_W-1:0] r_s1_load;
    logic signed [VAL_W-1:0] r_s1_grad;
    logic                    r_s1_err;

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_s1_type <= i_req.req_type;
            r_s1_idx  <= w_red_idx;
            r_s1_load <= i_req.load_value;
            r_s1_grad <= i_req.gradient;
            r_s1_err  <= i_req.error_increased;
        end
    end

    logic [STEP_W-1:0]         w_s_lim;
    logic [SPROD_W-1:0]        w_prod_grow, w_prod_shrink;
    logic signed [MPROD_W-1:0] w_prod_gain, w_prod_mom;

    // a step below the floor is raised, and one above the ceiling lowered, before use
    always_comb begin
        if (w_rd.step < STEP_MIN) begin
            w_s_lim = STEP_MIN;
        end else if (w_rd.step > STEP_MAX) begin
            w_s_lim = STEP_MAX;
        end else begin
            w_s_lim = w_rd.step;
        end
    end

    assign w_prod_grow   = SPROD_W'(w_s_lim) * SPROD_W'(r_grow_factor);
    assign w_prod_shrink = SPROD_W'(w_s_lim) * SPROD_W'(r_shrink_factor);
    assign w_prod_gain   = MPROD_W'($signed({1'b0, r_gain})) * MPROD_W'(r_s1_grad);
    assign w_prod_mom    = MPROD_W'($signed({1'b0, r_momentum_factor}))
                         * MPROD_W'(w_rd.last_change);

    // ---------------- stage 2: update rule ----------------
    logic                      r_s2_type;
    logic signed [VAL_W-1:0]   r_s2_load;
    logic signed [VAL_W-1:0]   r_s2_grad;
    logic                      r_s2_err;
    logic signed [VAL_W-1:0]   r_s2_weight;
    logic [STEP_W-1:0]         r_s2_step;
    logic [STEP_W-1:0]         r_s2_s_lim;
    logic signed [VAL_W-1:0]   r_s2_prev;
    logic signed [VAL_W-1:0]   r_s2_last;
    logic [SPROD_W-1:0]        r_s2_prod_grow, r_s2_prod_shrink;
    logic signed [MPROD_W-1:0] r_s2_prod_gain, r_s2_prod_mom;

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_s2_type        <= r_s1_type;
            r_s2_idx         <= r_s1_idx;
            r_s2_load        <= r_s1_load;
            r_s2_grad        <= r_s1_grad;
            r_s2_err         <= r_s1_err;
            r_s2_weight      <= w_rd.weight;
            r_s2_step        <= w_rd.step;
            r_s2_s_lim       <= w_s_lim;
            r_s2_prev        <= w_rd.prev_grad;
            r_s2_last        <= w_rd.last_change;
            r_s2_prod_grow   <= w_prod_grow;
            r_s2_prod_shrink <= w_prod_shrink;
            r_s2_prod_gain   <= w_prod_gain;
            r_s2_prod_mom    <= w_prod_mom;
        end
    end

    logic [STEP_W-1:0]       w_grow_s, w_shrink_s, w_init_s;
    logic signed [ACC_W-1:0] w_acc;
    logic signed [RND_W-1:0] w_rnd;
    logic signed [VAL_W-1:0] w_change;
    logic                    w_g_pos, w_g_neg, w_p_pos, w_p_neg;
    logic                    w_same, w_flip;
    logic signed [ADD_W-1:0] w_delta;

    assign w_grow_s   = clamp_step(r_s2_prod_grow[SPROD_W-1:FRAC_SHIFT]);
    assign w_shrink_s = clamp_step(r_s2_prod_shrink[SPROD_W-1:FRAC_SHIFT]);

    always_comb begin
        if (r_initial_step < STEP_MIN) begin
            w_init_s = STEP_MIN;
        end else if (r_initial_step > STEP_MAX) begin
            w_init_s = STEP_MAX;
        end else begin
            w_init_s = r_initial_step;
        end
    end

    // momentum change: round q.28 to q.16 with ties up, then saturate
    assign w_acc = ACC_W'(r_s2_prod_mom) - ACC_W'(r_s2_prod_gain) + $signed(ROUND_HALF);
    assign w_rnd = w_acc[ACC_W-1:FRAC_SHIFT];
    always_comb begin
        if (w_rnd[RND_W-1:VAL_W-1] == {(RND_W-VAL_W+1){w_rnd[VAL_W-1]}}) begin
            w_change = w_rnd[VAL_W-1:0];
        end else if (w_rnd[RND_W-1]) begin
            w_change = VAL_MIN;
        end else begin
            w_change = VAL_MAX;
        end
    end

    // only the signs of previous and current gradient matter
    assign w_g_neg = r_s2_grad[VAL_W-1];
    assign w_g_pos = !w_g_neg && (r_s2_grad != '0);
    assign w_p_neg = r_s2_prev[VAL_W-1];
    assign w_p_pos = !w_p_neg && (r_s2_prev != '0);
    assign w_same  = (w_p_pos && w_g_pos) || (w_p_neg && w_g_neg);
    assign w_flip  = (w_p_pos && w_g_neg) || (w_p_neg && w_g_pos);

    logic signed [VAL_W-1:0] n_s3_base;
    logic signed [ADD_W-1:0] n_s3_add;
    logic [STEP_W-1:0]       n_s3_step;
    logic signed [VAL_W-1:0] n_s3_prev;
    logic signed [VAL_W-1:0] n_s3_last;

    always_comb begin
        n_s3_base = r_s2_weight;
        n_s3_add  = '0;
        n_s3_step = r_s2_step;
        n_s3_prev = r_s2_prev;
        n_s3_last = r_s2_last;
        w_delta   = '0;
        if (r_s2_type == REQ_LOAD) begin
            n_s3_base = r_s2_load;
            n_s3_step = w_init_s;
            n_s3_prev = '0;
            n_s3_last = '0;
        end else begin
            case (r_algorithm) inside
                ALG_MOMENTUM: begin
                    n_s3_add  = ADD_W'(w_change);
                    n_s3_last = w_change;
                end
                ALG_RPROP_MINUS, ALG_IRPROP_MINUS: begin
                    if (w_same) begin
                        n_s3_step = w_grow_s;
                    end else if (w_flip) begin
                        n_s3_step = w_shrink_s;
                    end else begin
                        n_s3_step = r_s2_s_lim;
                    end
                    // irprop- forgets the gradient on a sign change
                    if ((r_algorithm == ALG_IRPROP_MINUS) && w_flip) begin
                        n_s3_prev = '0;
                    end else begin
                        n_s3_add  = step_delta(w_g_pos, w_g_neg, n_s3_step);
                        n_s3_prev = r_s2_grad;
                    end
                end
                ALG_RPROP, ALG_RPROP_PLUS, ALG_IRPROP_PLUS: begin
                    if (w_flip) begin
                        n_s3_step = w_shrink_s;
                        n_s3_prev = '0;
                        // weight backtracking
                        if ((r_algorithm == ALG_RPROP_PLUS)
                            || ((r_algorithm == ALG_IRPROP_PLUS) && r_s2_err)) begin
                            n_s3_add = -ADD_W'(r_s2_last);
                        end
                    end else begin
                        n_s3_step = w_same ? w_grow_s : r_s2_s_lim;
                        w_delta   = step_delta(w_g_pos, w_g_neg, n_s3_step);
                        n_s3_add  = w_delta;
                        n_s3_prev = r_s2_grad;
                        if (r_algorithm != ALG_RPROP) begin
                            n_s3_last = w_delta[VAL_W-1:0];
                        end
                    end
                end
                default: ;   // unused codes leave the entry as it is
            endcase
        end
    end

    // ---------------- stage 3: weight add, write back ----------------
    logic signed [VAL_W-1:0] r_s3_base;
    logic signed [ADD_W-1:0] r_s3_add;
    logic [STEP_W-1:0]       r_s3_step;
    logic signed [VAL_W-1:0] r_s3_prev;
    logic signed [VAL_W-1:0] r_s3_last;

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_s3_idx  <= r_s2_idx;
            r_s3_base <= n_s3_base;
            r_s3_add  <= n_s3_add;
            r_s3_step <= n_s3_step;
            r_s3_prev <= n_s3_prev;
            r_s3_last <= n_s3_last;
        end
    end

    logic signed [SUM_W-1:0] w_sum;
    logic signed [VAL_W-1:0] w_wsat;

    assign w_sum = SUM_W'(r_s3_base) + SUM_W'(r_s3_add);
    always_comb begin
        if (w_sum[SUM_W-1:VAL_W-1] == {(SUM_W-VAL_W+1){w_sum[VAL_W-1]}}) begin
            w_wsat = w_sum[VAL_W-1:0];
        end else if (w_sum[SUM_W-1]) begin
            w_wsat = VAL_MIN;
        end else begin
            w_wsat = VAL_MAX;
        end
    end

    // the entry is written as the request moves into the response register
    assign w_ram_we    = r_s3_v && w_en_out;
    assign w_ram_waddr = AW'(r_s3_idx);
    assign w_ram_wdata = '{weight:      w_wsat,
                           step:        r_s3_step,
                           prev_grad:   r_s3_prev,
                           last_change: r_s3_last};

    // ---------------- response register ----------------
    logic signed [VAL_W-1:0] r_out_weight;
    logic [STEP_W-1:0]       r_out_step;

    always_ff @(posedge i_clk) begin
        if (w_en_out) begin
            r_out_idx    <= r_s3_idx;
            r_out_weight <= w_wsat;
            r_out_step   <= r_s3_step;
        end
    end

    assign o_rsp.valid      = r_out_v;
    assign o_rsp.out_index  = r_out_idx;
    assign o_rsp.new_weight = r_out_weight;
    assign o_rsp.new_step   = r_out_step;
endmodule

// ===== src/rpwu_checker.sv =====
// rpwu_port_checker: port level assertions for the rprop weight update engine
module rpwu_port_checker import rpwu_pkg::*; #(
    parameter int NUM_WEIGHTS = 1024
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_req_valid,
    input logic              i_req_ready,
    input logic              i_rsp_valid,
    input logic              i_rsp_ready,
    input logic [IDX_W-1:0]  i_rsp_index,
    input logic [VAL_W-1:0]  i_rsp_weight,
    input logic [STEP_W-1:0] i_rsp_step
);
    localparam int PIPE_DEPTH = 4;
    localparam int CNT_W      = $clog2(PIPE_DEPTH + 1) + 1;

    logic [CNT_W-1:0] r_pending;
    logic [CNT_W-1:0] n_pending;

    // requests taken and not yet answered
    always_comb begin
        n_pending = r_pending;
        if (i_req_valid && i_req_ready) begin
            n_pending = n_pending + CNT_W'(1);
        end
        if (i_rsp_valid && i_rsp_ready) begin
            n_pending = n_pending - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= n_pending;
        end
    end

    a_reset_clears_rsp: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid after reset");

    a_rsp_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_index)
            && $stable(i_rsp_weight) && $stable(i_rsp_step))
        else $error("stalled response changed");

    a_rsp_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> r_pending != '0)
        else $error("response without an outstanding request");

    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= CNT_W'(PIPE_DEPTH))
        else $error("more requests in flight than pipeline stages");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> 32'(i_rsp_index) < NUM_WEIGHTS)
        else $error("response index beyond table");
endmodule

bind rprop_weight_update rpwu_port_checker #(
    .NUM_WEIGHTS(NUM_WEIGHTS)
) u_rpwu_port_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_index (o_rsp.out_index),
    .i_rsp_weight(o_rsp.new_weight),
    .i_rsp_step  (o_rsp.new_step)
);
